// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the rtl folder
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clk edge, ignored while rst_n is low
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// property checked on every clk edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lfps_pkg.sv =====
// ----------------------------------------------------------------------------
// lfps_pkg
// Types, widths and constants of the line follower steering controller
// ----------------------------------------------------------------------------
package lfps_pkg;

  // sizing
  localparam int ADC_BITS      = 12;
  localparam int INTEGRAL_BITS = 24;
  localparam int FRAC_BITS     = 32;
  localparam int HISTORY_DEPTH = 3;
  localparam int NSENS         = 5;
  localparam int SPD_W         = 7;
  localparam int ACT_W         = 3;
  localparam int IDX_W         = 3;
  localparam int CFG_W         = (ADC_BITS > SPD_W) ? ADC_BITS : SPD_W;

  // pid datapath widths
  localparam int PID_CENTRE = 1500;
  localparam int G_W        = ((ADC_BITS > 11) ? ADC_BITS : 11) + 1;
  localparam int DIFF_W     = ADC_BITS + 1;
  localparam int ERR_W      = DIFF_W - 3;
  localparam int D_W        = ERR_W + 1;
  localparam int MA_W       = (G_W > FRAC_BITS - 6) ? G_W : FRAC_BITS - 6;
  localparam int MB_W       = (G_W + D_W > INTEGRAL_BITS) ? G_W + D_W : INTEGRAL_BITS;
  localparam int PROD_W     = MA_W + MB_W;
  localparam int ACC_W      = (PROD_W + 2 > SPD_W + FRAC_BITS + 2) ?
                              PROD_W + 2 : SPD_W + FRAC_BITS + 2;
  localparam int SPDQ_W     = ACC_W - FRAC_BITS;

  // gains, rounded to nearest with FRAC_BITS fraction bits
  localparam logic [63:0] KP_Q = ((64'd85 << FRAC_BITS) + 64'd500000) / 64'd1000000;
  localparam logic [63:0] KD_Q = ((64'd75 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam logic [63:0] KI_Q = ((64'd15 << FRAC_BITS) + 64'd500000) / 64'd1000000;

  // fixed pivot speeds
  localparam logic [SPD_W-1:0] PIVOT_FWD = SPD_W'(25);
  localparam logic [SPD_W-1:0] PIVOT_REV = SPD_W'(15);

  // register map
  localparam logic [IDX_W-1:0] REG_THRESHOLD_LAST = IDX_W'(NSENS - 1);
  localparam logic [IDX_W-1:0] REG_BASE_SPEED     = IDX_W'(5);
  localparam logic [IDX_W-1:0] REG_SPEED_LIMIT    = IDX_W'(6);

  // register reset values
  localparam logic [ADC_BITS-1:0] THR_RESET [NSENS] = '{
    ADC_BITS'(2500), ADC_BITS'(2500), ADC_BITS'(3000), ADC_BITS'(2500), ADC_BITS'(2500)
  };
  localparam logic [SPD_W-1:0] BASE_SPEED_RESET  = SPD_W'(35);
  localparam logic [SPD_W-1:0] SPEED_LIMIT_RESET = SPD_W'(65);

  typedef enum logic [ACT_W-1:0] {
    ACT_HOLD    = 3'd0,
    ACT_STOP    = 3'd1,
    ACT_PIVOT_L = 3'd2,
    ACT_PIVOT_R = 3'd3,
    ACT_PID     = 3'd4,
    ACT_NONE    = 3'd5
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASS,
    ST_MUL_GE,
    ST_MUL_KP,
    ST_MUL_GD,
    ST_MUL_KD,
    ST_MUL_KI,
    ST_SUM,
    ST_SPEED,
    ST_FINISH
  } state_t;

endpackage

// ===== rtl/line_follow_pid_steering.sv =====
// ----------------------------------------------------------------------------
// line_follow_pid_steering
// Line follower steering controller: threshold classifier plus PID drive
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one request carries five sensor samples, taken on in_valid and
//            in_ready both high. in_ready is high only while the sequencer
//            is idle.
//   out_*  : one motor command per request, held in an output register until
//            out_ready is seen with out_valid.
//   cfg_*  : register writes (thresholds, base speed, speed limit), always
//            taken; only to be written while the block is idle.
// Hold, stop, pivot and no command go from the classify step straight to the
//   final step; a PID drive first runs five multiplies through the single
//   shared multiplier, then the sum and speed steps.
// A new request is taken only once the previous one has left the sequencer;
//   it is taken while the previous command still waits in the output register.
// A stalled receiver holds the command; the sequencer then waits in its
//   final step until the output register is free.
// Reset (rst_n low, synchronous): registers return to their defaults and the
//   PID state and all-high history are cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module line_follow_pid_steering
  import lfps_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // sensor requests
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ADC_BITS-1:0] in_sensor_0,
  input  logic [ADC_BITS-1:0] in_sensor_1,
  input  logic [ADC_BITS-1:0] in_sensor_2,
  input  logic [ADC_BITS-1:0] in_sensor_3,
  input  logic [ADC_BITS-1:0] in_sensor_4,
  // motor commands
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ACT_W-1:0]    out_action,
  output logic                out_left_reverse,
  output logic [SPD_W-1:0]    out_left_speed,
  output logic                out_right_reverse,
  output logic [SPD_W-1:0]    out_right_speed,
  // register writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  // clamp a fixed point speed to 0..limit
  function automatic logic [SPD_W-1:0] clamp_speed(input logic signed [ACC_W-1:0] q,
                                                   input logic [SPD_W-1:0] limit);
    logic [SPDQ_W-1:0] whole;
    whole = q[ACC_W-1:FRAC_BITS];
    if (q <= 0)
      return '0;
    else if (whole > SPDQ_W'(limit))
      return limit;
    else
      return whole[SPD_W-1:0];
  endfunction

  // registers
  state_t                       state_r, state_nxt;
  logic [ADC_BITS-1:0]          thr_r [NSENS];
  logic [SPD_W-1:0]             base_r;
  logic [SPD_W-1:0]             limit_r;
  logic [ADC_BITS-1:0]          sens_r [NSENS];
  logic [ADC_BITS-1:0]          sens_nxt [NSENS];
  logic signed [ERR_W-1:0]      prev_err_r, prev_err_nxt;
  logic signed [INTEGRAL_BITS-1:0] integ_r, integ_nxt;
  logic [HISTORY_DEPTH-1:0]     hist_r, hist_nxt;
  logic signed [G_W-1:0]        g_r, g_nxt;
  logic signed [ERR_W-1:0]      err_r, err_nxt;
  logic signed [D_W-1:0]        d_r, d_nxt;
  logic signed [PROD_W-1:0]     prod_r, prod_nxt;
  logic signed [ACC_W-1:0]      acc_r, acc_nxt;
  action_t                      act_r, act_nxt;
  logic                         lrev_r, lrev_nxt, rrev_r, rrev_nxt;
  logic [SPD_W-1:0]             lspd_r, lspd_nxt, rspd_r, rspd_nxt;
  logic                         out_valid_r, out_valid_nxt;
  action_t                      out_act_r, out_act_nxt;
  logic                         out_lrev_r, out_lrev_nxt, out_rrev_r, out_rrev_nxt;
  logic [SPD_W-1:0]             out_lspd_r, out_lspd_nxt, out_rspd_r, out_rspd_nxt;

  // classifier and pid front end
  logic [NSENS-1:0]             above, below;
  logic                         all_high;
  logic [HISTORY_DEPTH:0]       hist_shift;
  logic signed [DIFF_W-1:0]     diff, diff_adj;
  logic signed [ERR_W-1:0]      err_c;
  logic signed [INTEGRAL_BITS:0] integ_sum;
  logic signed [MA_W-1:0]       mul_a;
  logic signed [MB_W-1:0]       mul_b;
  logic signed [PROD_W-1:0]     mul_p;
  logic signed [ACC_W-1:0]      base_q;
  logic                         in_fire, out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  // threshold compares
  always_comb begin
    for (int i = 0; i < NSENS; i++) begin
      above[i] = sens_r[i] > thr_r[i];
      below[i] = sens_r[i] < thr_r[i];
    end
  end
  assign all_high   = &above;
  assign hist_shift = {hist_r, all_high};

  // error, truncated toward zero, and saturated integral
  assign diff     = signed'(DIFF_W'(sens_r[1])) - signed'(DIFF_W'(sens_r[3]));
  assign diff_adj = diff + (diff[DIFF_W-1] ? DIFF_W'(7) : DIFF_W'(0));
  assign err_c    = diff_adj[DIFF_W-1:3];
  assign integ_sum = (INTEGRAL_BITS+1)'(integ_r) + (INTEGRAL_BITS+1)'(err_c);

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      ST_MUL_GE: begin
        mul_a = MA_W'(g_r);
        mul_b = MB_W'(err_r);
      end
      ST_MUL_KP: begin
        mul_a = signed'(MA_W'(KP_Q));
        mul_b = prod_r[MB_W-1:0];
      end
      ST_MUL_GD: begin
        mul_a = MA_W'(g_r);
        mul_b = MB_W'(d_r);
      end
      ST_MUL_KD: begin
        mul_a = signed'(MA_W'(KD_Q));
        mul_b = prod_r[MB_W-1:0];
      end
      ST_MUL_KI: begin
        mul_a = signed'(MA_W'(KI_Q));
        mul_b = MB_W'(integ_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p  = mul_a * mul_b;
  assign base_q = signed'(ACC_W'(base_r) << FRAC_BITS);

  // sequencer: next state and datapath
  always_comb begin
    state_nxt     = state_r;
    sens_nxt      = sens_r;
    prev_err_nxt  = prev_err_r;
    integ_nxt     = integ_r;
    hist_nxt      = hist_r;
    g_nxt         = g_r;
    err_nxt       = err_r;
    d_nxt         = d_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    act_nxt       = act_r;
    lrev_nxt      = lrev_r;
    rrev_nxt      = rrev_r;
    lspd_nxt      = lspd_r;
    rspd_nxt      = rspd_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_act_nxt   = out_act_r;
    out_lrev_nxt  = out_lrev_r;
    out_rrev_nxt  = out_rrev_r;
    out_lspd_nxt  = out_lspd_r;
    out_rspd_nxt  = out_rspd_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          sens_nxt[0] = in_sensor_0;
          sens_nxt[1] = in_sensor_1;
          sens_nxt[2] = in_sensor_2;
          sens_nxt[3] = in_sensor_3;
          sens_nxt[4] = in_sensor_4;
          state_nxt   = ST_CLASS;
        end
      end
      ST_CLASS: begin
        hist_nxt  = hist_shift[HISTORY_DEPTH-1:0];
        act_nxt   = ACT_NONE;
        lrev_nxt  = 1'b0;
        rrev_nxt  = 1'b0;
        lspd_nxt  = '0;
        rspd_nxt  = '0;
        state_nxt = ST_FINISH;
        if (all_high && (&hist_r)) begin
          act_nxt = ACT_HOLD;
        end else if (!(|above)) begin
          act_nxt = ACT_STOP;
        end else if (below[0] && above[NSENS-1]) begin
          act_nxt  = ACT_PIVOT_L;
          lrev_nxt = 1'b1;
          lspd_nxt = PIVOT_REV;
          rspd_nxt = PIVOT_FWD;
        end else if (above[0] && below[NSENS-1]) begin
          act_nxt  = ACT_PIVOT_R;
          rrev_nxt = 1'b1;
          rspd_nxt = PIVOT_REV;
          lspd_nxt = PIVOT_FWD;
        end else if (below[2]) begin
          act_nxt      = ACT_PID;
          g_nxt        = signed'(G_W'(PID_CENTRE)) - signed'(G_W'(sens_r[2]));
          err_nxt      = err_c;
          d_nxt        = D_W'(err_c) - D_W'(prev_err_r);
          prev_err_nxt = err_c;
          if (integ_sum[INTEGRAL_BITS] != integ_sum[INTEGRAL_BITS-1])
            integ_nxt = integ_sum[INTEGRAL_BITS] ?
                        {1'b1, {(INTEGRAL_BITS-1){1'b0}}} :
                        {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
          else
            integ_nxt = integ_sum[INTEGRAL_BITS-1:0];
          state_nxt = ST_MUL_GE;
        end
      end
      ST_MUL_GE: begin
        prod_nxt  = mul_p;
        state_nxt = ST_MUL_KP;
      end
      ST_MUL_KP: begin
        prod_nxt  = mul_p;
        state_nxt = ST_MUL_GD;
      end
      ST_MUL_GD: begin
        acc_nxt   = ACC_W'(prod_r);
        prod_nxt  = mul_p;
        state_nxt = ST_MUL_KD;
      end
      ST_MUL_KD: begin
        prod_nxt  = mul_p;
        state_nxt = ST_MUL_KI;
      end
      ST_MUL_KI: begin
        acc_nxt   = acc_r + ACC_W'(prod_r);
        prod_nxt  = mul_p;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        acc_nxt   = acc_r + ACC_W'(prod_r);
        state_nxt = ST_SPEED;
      end
      ST_SPEED: begin
        lspd_nxt  = clamp_speed(base_q - acc_r, limit_r);
        rspd_nxt  = clamp_speed(base_q + acc_r, limit_r);
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_act_nxt   = act_r;
          out_lrev_nxt  = lrev_r;
          out_rrev_nxt  = rrev_r;
          out_lspd_nxt  = lspd_r;
          out_rspd_nxt  = rspd_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control state, pid state and register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      prev_err_r  <= '0;
      integ_r     <= '0;
      hist_r      <= '0;
      for (int i = 0; i < NSENS; i++) thr_r[i] <= THR_RESET[i];
      base_r      <= BASE_SPEED_RESET;
      limit_r     <= SPEED_LIMIT_RESET;
    end else begin
      out_valid_r <= out_valid_nxt;
      prev_err_r  <= prev_err_nxt;
      integ_r     <= integ_nxt;
      hist_r      <= hist_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index <= REG_THRESHOLD_LAST)
          thr_r[cfg_index] <= cfg_data[ADC_BITS-1:0];
        else if (cfg_index == REG_BASE_SPEED)
          base_r <= cfg_data[SPD_W-1:0];
        else if (cfg_index == REG_SPEED_LIMIT)
          limit_r <= cfg_data[SPD_W-1:0];
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    sens_r     <= sens_nxt;
    g_r        <= g_nxt;
    err_r      <= err_nxt;
    d_r        <= d_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    act_r      <= act_nxt;
    lrev_r     <= lrev_nxt;
    rrev_r     <= rrev_nxt;
    lspd_r     <= lspd_nxt;
    rspd_r     <= rspd_nxt;
    out_act_r  <= out_act_nxt;
    out_lrev_r <= out_lrev_nxt;
    out_rrev_r <= out_rrev_nxt;
    out_lspd_r <= out_lspd_nxt;
    out_rspd_r <= out_rspd_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_action        = out_act_r;
  assign out_left_reverse  = out_lrev_r;
  assign out_left_speed    = out_lspd_r;
  assign out_right_reverse = out_rrev_r;
  assign out_right_speed   = out_rspd_r;

  // checks
  `ASSERT_CLK(a_accept_to_class, in_valid && in_ready |=> state_r == ST_CLASS,
              "accepted request did not start classification")
  `ASSERT_CLK(a_pid_speed_clamped,
              out_valid && out_action == ACT_PID |->
                out_left_speed <= limit_r && out_right_speed <= limit_r,
              "pid speed above speed limit")
  `ASSERT_CLK(a_hold_quiet,
              out_valid && (out_action == ACT_HOLD || out_action == ACT_NONE) |->
                out_left_speed == '0 && out_right_speed == '0 &&
                !out_left_reverse && !out_right_reverse,
              "hold or no-command result carries motor drive")
  `ASSERT_CLK(a_pivot_dir,
              out_valid && out_action == ACT_PIVOT_L |->
                out_left_reverse && !out_right_reverse,
              "pivot left with wrong wheel directions")
  `ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid && in_ready,
                 "block not idle after reset")

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the line follower steering controller
// ----------------------------------------------------------------------------
// Sensor requests go in through the valid/ready input channel, and every motor
// command that comes out is compared field by field with the oldest expected
// command queued at acceptance: a pinned table row or a local steering predictor.
// A short table of directed requests runs first at reset settings. Random
// requests follow over several register settings and idling patterns. Short
// runs of PID requests at the largest positive and negative error close the run.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import lfps_pkg::*;

  // run sizing
  localparam int CYCLE_LIMIT       = 4_000_000;
  localparam int ITEMS_PER_SETTING = 250;
  localparam int NUM_SETTINGS      = 6;
  localparam int NUM_PROBES        = 19;
  localparam int SHOWN_ERRORS      = 10;
  localparam int RAMP_ITEMS        = 40;

  // steering constants, gains rounded to nearest with FRAC_BITS fraction bits
  localparam longint GAIN_P  = ((longint'(85) << FRAC_BITS) + 500000) / 1000000;
  localparam longint GAIN_D  = ((longint'(75) << FRAC_BITS) + 5000) / 10000;
  localparam longint GAIN_I  = ((longint'(15) << FRAC_BITS) + 500000) / 1000000;
  localparam longint SUM_MAX = (longint'(1) << (INTEGRAL_BITS - 1)) - 1;
  localparam longint SUM_MIN = -SUM_MAX - 1;
  localparam int     CENTRE_REF = 1500;
  localparam logic [SPD_W-1:0] TURN_OUTER = 7'd25;
  localparam logic [SPD_W-1:0] TURN_INNER = 7'd15;

  // register map entry with nothing behind it
  localparam logic [IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef logic [0:NSENS-1][ADC_BITS-1:0] level_set_t;

  typedef struct packed {
    action_t          action;
    logic             left_rev;
    logic [SPD_W-1:0] left_spd;
    logic             right_rev;
    logic [SPD_W-1:0] right_spd;
  } motor_cmd_t;

  typedef struct packed {
    level_set_t lv;
    logic       pinned;
    motor_cmd_t cmd;
  } probe_t;

  localparam level_set_t       THR_DEFAULT   = {12'd2500, 12'd2500, 12'd3000,
                                                12'd2500, 12'd2500};
  localparam logic [SPD_W-1:0] BASE_DEFAULT  = 7'd35;
  localparam logic [SPD_W-1:0] LIMIT_DEFAULT = 7'd65;

  localparam motor_cmd_t CMD_HOLD = '{ACT_HOLD, 1'b0, 7'd0, 1'b0, 7'd0};
  localparam motor_cmd_t CMD_STOP = '{ACT_STOP, 1'b0, 7'd0, 1'b0, 7'd0};
  localparam motor_cmd_t CMD_NONE = '{ACT_NONE, 1'b0, 7'd0, 1'b0, 7'd0};
  localparam motor_cmd_t CMD_PVL  = '{ACT_PIVOT_L, 1'b1, TURN_INNER, 1'b0, TURN_OUTER};
  localparam motor_cmd_t CMD_PVR  = '{ACT_PIVOT_R, 1'b0, TURN_OUTER, 1'b1, TURN_INNER};

  // directed requests at reset settings; unpinned rows go to the predictor
  localparam probe_t PROBES [NUM_PROBES] = '{
    '{{12'd0,    12'd0,    12'd0,    12'd0,    12'd0   }, 1'b1, CMD_STOP},
    '{{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095}, 1'b1, CMD_NONE},
    '{{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095}, 1'b1, CMD_NONE},
    '{{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095}, 1'b1, CMD_NONE},
    '{{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095}, 1'b1, CMD_HOLD},
    '{{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095}, 1'b1, CMD_HOLD},
    '{{12'd0,    12'd0,    12'd0,    12'd0,    12'd4095}, 1'b1, CMD_PVL },
    '{{12'd4095, 12'd0,    12'd0,    12'd0,    12'd0   }, 1'b1, CMD_PVR },
    '{{12'd2500, 12'd2500, 12'd3000, 12'd2500, 12'd2500}, 1'b1, CMD_STOP},
    '{{12'd2501, 12'd2501, 12'd3001, 12'd2501, 12'd2501}, 1'b1, CMD_NONE},
    '{{12'd2500, 12'd2500, 12'd2999, 12'd2500, 12'd4095}, 1'b0, CMD_NONE},
    '{{12'd0,    12'd4095, 12'd0,    12'd0,    12'd0   }, 1'b0, CMD_NONE},
    '{{12'd0,    12'd0,    12'd2999, 12'd4095, 12'd0   }, 1'b0, CMD_NONE},
    '{{12'd0,    12'd2600, 12'd1500, 12'd2609, 12'd0   }, 1'b0, CMD_NONE},
    '{{12'd0,    12'd4095, 12'd4095, 12'd4095, 12'd0   }, 1'b1, CMD_NONE},
    '{{12'd4095, 12'd4095, 12'd0,    12'd4095, 12'd4095}, 1'b0, CMD_NONE},
    '{{12'd0,    12'd0,    12'd0,    12'd0,    12'd2500}, 1'b1, CMD_STOP},
    '{{12'd2500, 12'd0,    12'd0,    12'd0,    12'd4095}, 1'b0, CMD_NONE},
    '{{12'd4095, 12'd0,    12'd2000, 12'd4095, 12'd2500}, 1'b0, CMD_NONE}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid    = 1'b0;
  logic                in_ready;
  logic [ADC_BITS-1:0] in_sensor_0 = '0;
  logic [ADC_BITS-1:0] in_sensor_1 = '0;
  logic [ADC_BITS-1:0] in_sensor_2 = '0;
  logic [ADC_BITS-1:0] in_sensor_3 = '0;
  logic [ADC_BITS-1:0] in_sensor_4 = '0;

  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [ACT_W-1:0]    out_action;
  logic                out_left_reverse;
  logic [SPD_W-1:0]    out_left_speed;
  logic                out_right_reverse;
  logic [SPD_W-1:0]    out_right_speed;

  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data  = '0;

  // steering mirror: registers and controller state
  level_set_t       thr_cfg;
  logic [SPD_W-1:0] base_cfg;
  logic [SPD_W-1:0] lim_cfg;
  longint           prev_err;
  longint           sum_acc;
  logic [HISTORY_DEPTH-1:0] high_hist;

  motor_cmd_t pending_cmds [$];
  motor_cmd_t row_cmd;
  motor_cmd_t want_cmd;
  logic       row_pinned = 1'b0;
  int         bad_cmds   = 0;
  int         cycle_cnt  = 0;
  int         req_gap_pct = 14;
  int         stall_pct   = 74;

  line_follow_pid_steering dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sensor_0       (in_sensor_0),
    .in_sensor_1       (in_sensor_1),
    .in_sensor_2       (in_sensor_2),
    .in_sensor_3       (in_sensor_3),
    .in_sensor_4       (in_sensor_4),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_action        (out_action),
    .out_left_reverse  (out_left_reverse),
    .out_left_speed    (out_left_speed),
    .out_right_reverse (out_right_reverse),
    .out_right_speed   (out_right_speed),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #2 clk = ~clk;

  // run guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // register write into the mirror
  function automatic void set_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    if (idx <= REG_THRESHOLD_LAST)
      thr_cfg[idx] = data[ADC_BITS-1:0];
    else if (idx == REG_BASE_SPEED)
      base_cfg = data[SPD_W-1:0];
    else if (idx == REG_SPEED_LIMIT)
      lim_cfg = data[SPD_W-1:0];
  endfunction

  // fixed-point speed to wheel command, floored and clamped to the limit
  function automatic logic [SPD_W-1:0] wheel_speed(longint q);
    longint whole;
    if (q <= 0)
      return '0;
    whole = q >>> FRAC_BITS;
    if (whole > longint'(lim_cfg))
      whole = longint'(lim_cfg);
    return whole[SPD_W-1:0];
  endfunction

  // next motor command for one sensor snapshot, advancing the mirror state
  function automatic motor_cmd_t predict_command(level_set_t lv);
    motor_cmd_t cmd;
    int         n_above;
    bit         all_high;
    longint     g, err, d, pid, base_q;
    cmd     = CMD_NONE;
    n_above = 0;
    for (int i = 0; i < NSENS; i++)
      if (lv[i] > thr_cfg[i])
        n_above++;
    all_high = (n_above == NSENS);

    if (all_high && (&high_hist)) begin
      cmd = CMD_HOLD;
    end else if (n_above == 0) begin
      cmd = CMD_STOP;
    end else if (lv[0] < thr_cfg[0] && lv[4] > thr_cfg[4]) begin
      cmd = CMD_PVL;
    end else if (lv[0] > thr_cfg[0] && lv[4] < thr_cfg[4]) begin
      cmd = CMD_PVR;
    end else if (lv[2] < thr_cfg[2]) begin
      // pid drive: the P and D terms scale with distance of the centre sample from the reference
      g   = CENTRE_REF - longint'(lv[2]);
      err = (longint'(lv[1]) - longint'(lv[3])) / 8;
      d   = err - prev_err;
      sum_acc = sum_acc + err;
      if (sum_acc > SUM_MAX)
        sum_acc = SUM_MAX;
      if (sum_acc < SUM_MIN)
        sum_acc = SUM_MIN;
      pid      = GAIN_P * g * err + GAIN_I * sum_acc + GAIN_D * g * d;
      prev_err = err;
      base_q   = longint'(base_cfg) << FRAC_BITS;
      cmd.action    = ACT_PID;
      cmd.left_spd  = wheel_speed(base_q - pid);
      cmd.right_spd = wheel_speed(base_q + pid);
    end

    high_hist = {high_hist[HISTORY_DEPTH-2:0], all_high};
    return cmd;
  endfunction

  task automatic flag_command(bit unexpected, motor_cmd_t want);
    if (bad_cmds < SHOWN_ERRORS) begin
      if (unexpected)
        $display("unexpected command: act %0d lrev %0d lspd %0d rrev %0d rspd %0d",
                 out_action, out_left_reverse, out_left_speed,
                 out_right_reverse, out_right_speed);
      else begin
        $write("command mismatch (act lrev lspd rrev rspd): expected %0d %0d %0d %0d %0d,",
               want.action, want.left_rev, want.left_spd, want.right_rev, want.right_spd);
        $display(" got %0d %0d %0d %0d %0d",
                 out_action, out_left_reverse, out_left_speed,
                 out_right_reverse, out_right_speed);
      end
    end
    bad_cmds++;
  endtask

  // accepted writes, commands and requests, in that order within one edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready)
        set_register(cfg_index, cfg_data);

      if (out_valid && out_ready) begin
        if (pending_cmds.size() == 0) begin
          flag_command(1'b1, CMD_NONE);
        end else begin
          want_cmd = pending_cmds.pop_front();
          if (out_action !== want_cmd.action || out_left_reverse !== want_cmd.left_rev ||
              out_left_speed !== want_cmd.left_spd ||
              out_right_reverse !== want_cmd.right_rev ||
              out_right_speed !== want_cmd.right_spd)
            flag_command(1'b0, want_cmd);
        end
      end

      if (in_valid && in_ready) begin
        want_cmd = predict_command({in_sensor_0, in_sensor_1, in_sensor_2,
                                    in_sensor_3, in_sensor_4});
        pending_cmds.push_back(row_pinned ? row_cmd : want_cmd);
      end
    end
  end

  // one sensor request, entered and left at a falling edge
  task automatic send_levels(level_set_t lv, logic pinned, motor_cmd_t cmd);
    while ($urandom_range(99) < req_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_sensor_0 <= lv[0];
    in_sensor_1 <= lv[1];
    in_sensor_2 <= lv[2];
    in_sensor_3 <= lv[3];
    in_sensor_4 <= lv[4];
    row_pinned  = pinned;
    row_cmd     = cmd;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // stop requesting and let every outstanding command come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_cmds.size() != 0);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // all registers plus the unmapped index, back to back
  task automatic program_setting(level_set_t thr_v, logic [SPD_W-1:0] base_v,
                                 logic [SPD_W-1:0] lim_v);
    for (int i = 0; i < NSENS; i++)
      write_reg(IDX_W'(i), CFG_W'(thr_v[i]));
    write_reg(REG_BASE_SPEED, CFG_W'(base_v));
    write_reg(REG_SPEED_LIMIT, CFG_W'(lim_v));
    write_reg(REG_UNMAPPED, CFG_W'($urandom_range(4095)));
    cfg_valid <= 1'b0;
  endtask

  // sample relative to a threshold: below, above, equal or anywhere
  function automatic logic [ADC_BITS-1:0] level_near(logic [ADC_BITS-1:0] t, int how);
    case (how)
      0:       return (t == 0) ? t : ADC_BITS'($urandom_range(t - 1, 0));
      1:       return (t == 12'd4095) ? t : ADC_BITS'($urandom_range(4095, t + 1));
      2:       return t;
      default: return ADC_BITS'($urandom_range(4095));
    endcase
  endfunction

  function automatic level_set_t random_levels();
    level_set_t lv;
    int         pick;
    bit         raw;
    raw = ($urandom_range(3) == 0);
    for (int i = 0; i < NSENS; i++) begin
      pick = $urandom_range(9);
      if (raw || pick == 9)
        lv[i] = level_near(thr_cfg[i], 3);
      else if (pick == 8)
        lv[i] = level_near(thr_cfg[i], 2);
      else
        lv[i] = level_near(thr_cfg[i], pick / 4);
    end
    return lv;
  endfunction

  function automatic level_set_t all_high_levels();
    level_set_t lv;
    for (int i = 0; i < NSENS; i++)
      lv[i] = level_near(thr_cfg[i], 1);
    return lv;
  endfunction

  // pid request with the error pinned near its positive or negative extreme
  function automatic level_set_t ramp_levels(bit up);
    level_set_t lv;
    lv[0] = level_near(thr_cfg[0], 0);
    lv[2] = level_near(thr_cfg[2], 0);
    lv[4] = level_near(thr_cfg[4], 0);
    lv[1] = up ? ADC_BITS'($urandom_range(4095, 4088)) : ADC_BITS'($urandom_range(7, 0));
    lv[3] = up ? ADC_BITS'($urandom_range(7, 0)) : ADC_BITS'($urandom_range(4095, 4088));
    return lv;
  endfunction

  // stimulus
  initial begin
    level_set_t       thr_v;
    logic [SPD_W-1:0] base_v;
    logic [SPD_W-1:0] lim_v;
    int               burst;
    int               sent;
    thr_cfg   = THR_DEFAULT;
    base_cfg  = BASE_DEFAULT;
    lim_cfg   = LIMIT_DEFAULT;
    prev_err  = 0;
    sum_acc   = 0;
    high_hist = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table at reset settings
    for (int k = 0; k < NUM_PROBES; k++)
      send_levels(PROBES[k].lv, PROBES[k].pinned, PROBES[k].cmd);

    // random requests over a range of settings
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      drain();
      for (int i = 0; i < NSENS; i++)
        thr_v[i] = ADC_BITS'($urandom_range(3500, 500));
      case (p)
        0: begin
          for (int i = 0; i < NSENS; i++)
            thr_v[i] = ADC_BITS'($urandom_range(4095));
          base_v = SPD_W'($urandom_range(100));
          lim_v  = SPD_W'($urandom_range(100));
        end
        1: begin
          thr_v  = '0;
          base_v = 7'd100;
          lim_v  = 7'd100;
        end
        2: begin
          thr_v  = '1;
          base_v = 7'd0;
          lim_v  = 7'd0;
        end
        3: begin
          // base above the limit
          base_v = 7'd100;
          lim_v  = 7'd20;
        end
        4: begin
          base_v = 7'd0;
          lim_v  = 7'd100;
        end
        default: begin
          thr_v  = THR_DEFAULT;
          base_v = BASE_DEFAULT;
          lim_v  = LIMIT_DEFAULT;
        end
      endcase
      program_setting(thr_v, base_v, lim_v);

      req_gap_pct = (p < 2) ? 14 : (p < 4) ? 74 : 0;
      stall_pct   = (p < 2) ? 74 : (p < 4) ? 14 : 0;

      sent = 0;
      while (sent < ITEMS_PER_SETTING) begin
        if ($urandom_range(9) == 0) begin
          // run of all-high snapshots to fill the history
          burst = $urandom_range(6, 3);
          repeat (burst) send_levels(all_high_levels(), 1'b0, CMD_NONE);
          sent += burst;
        end else begin
          send_levels(random_levels(), 1'b0, CMD_NONE);
          sent++;
        end
      end
    end

    // largest positive and then largest negative error through the pid path
    drain();
    repeat (RAMP_ITEMS) send_levels(ramp_levels(1'b1), 1'b0, CMD_NONE);
    repeat (RAMP_ITEMS) send_levels(ramp_levels(1'b0), 1'b0, CMD_NONE);

    drain();
    repeat (20) @(negedge clk);
    if (bad_cmds == 0 && pending_cmds.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
